FILE: design/psch_pkg.sv
// shared constants and types of the preemptive priority scheduler
package psch_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int ID_W   = 16;
    localparam int ARR_W  = 12;
    localparam int BUR_W  = 12;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 17;
    localparam int TOT_W  = 21;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
        logic [PRI_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] best;
        logic [BUR_W-1:0] best_rem;
    } sel_t;

endpackage

FILE: design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: loads up to MAX_PROCS (16) process entries, one request per
// cycle, until one marked last_entry; further entries are dropped and flagged. It then
// simulates preemptive priority scheduling from tick 0. For each simulated tick, one shared
// compare unit walks the entry store one entry per cycle to find the ready entry with the
// smallest priority number (lowest index on ties), then the tick state charges the tick. The
// number of simulated ticks for N loaded entries is at least the sum of the bursts and at
// most about 4096 + N * 4095. Results then leave one per cycle in load order while out_ready
// is high; in_ready is low from the last entry until the final result sits in the output
// register.
module preemptive_priority_scheduler
    import psch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ID_W-1:0]   process_id,
    input  logic [ARR_W-1:0]  arrival_time,
    input  logic [BUR_W-1:0]  burst_time,
    input  logic [PRI_W-1:0]  priority_req,
    input  logic              last_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   out_process_id,
    output logic [TIME_W-1:0] completion_time,
    output logic [TIME_W-1:0] turnaround_time,
    output logic [TIME_W-1:0] waiting_time,
    output logic              last_result,
    output logic [TOT_W-1:0]  total_turnaround,
    output logic [TOT_W-1:0]  total_waiting,
    output logic              entries_dropped
);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        state_reg,    state_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [CNT_W-1:0]  fin_reg,      fin_next;
    logic [IDX_W-1:0]  idx_reg,      idx_next;
    logic [TIME_W-1:0] time_reg,     time_next;
    logic              ovf_reg,      ovf_next;
    logic [TOT_W-1:0]  tot_tat_reg,  tot_tat_next;
    logic [TOT_W-1:0]  tot_wt_reg,   tot_wt_next;
    logic              out_vld_reg,  out_vld_next;

    logic              in_acc;
    logic              load_en;
    logic              at_last_idx;
    logic              out_fire;
    logic              done_entry;
    logic [TIME_W-1:0] time_inc;
    entry_t            load_entry;
    entry_t            rd_entry;
    logic [BUR_W-1:0]  rd_rem;
    logic [TIME_W-1:0] rd_comp;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic [TOT_W-1:0]  tat_sum;
    logic [TOT_W-1:0]  wt_sum;
    sel_t              sel;

    assign in_ready    = (state_reg == S_LOAD);
    assign in_acc      = in_valid && in_ready;
    assign load_en     = in_acc && (count_reg < CNT_W'(MAX_PROCS));
    assign at_last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign out_fire    = (state_reg == S_OUT) && (!out_vld_reg || out_ready);
    assign time_inc    = time_reg + TIME_W'(1);
    assign done_entry  = sel.found && (sel.best_rem == BUR_W'(1));

    // zero burst is taken as one tick
    assign load_entry.id  = process_id;
    assign load_entry.arr = arrival_time;
    assign load_entry.bur = (burst_time == '0) ? BUR_W'(1) : burst_time;
    assign load_entry.pri = priority_req;

    psch_regfile u_regfile (
        .clk        (clk),
        .load_en    (load_en),
        .load_idx   (count_reg[IDX_W-1:0]),
        .load_entry (load_entry),
        .rem_we     ((state_reg == S_TICK) && sel.found),
        .comp_we    ((state_reg == S_TICK) && done_entry),
        .wr_idx     (sel.best),
        .rem_wdata  (sel.best_rem - BUR_W'(1)),
        .comp_wdata (time_inc),
        .rd_idx     (idx_reg),
        .rd_entry   (rd_entry),
        .rd_rem     (rd_rem),
        .rd_comp    (rd_comp)
    );

    psch_scan_unit u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (state_reg == S_SCAN),
        .first    (idx_reg == '0),
        .idx      (idx_reg),
        .rd_entry (rd_entry),
        .rd_rem   (rd_rem),
        .cur_time (time_reg),
        .sel      (sel)
    );

    // per-entry result figures for the output phase
    assign tat     = rd_comp - TIME_W'(rd_entry.arr);
    assign wt      = tat - TIME_W'(rd_entry.bur);
    assign tat_sum = tot_tat_reg + TOT_W'(tat);
    assign wt_sum  = tot_wt_reg + TOT_W'(wt);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        idx_next     = idx_reg;
        time_next    = time_reg;
        ovf_next     = ovf_reg;
        tot_tat_next = tot_tat_reg;
        tot_wt_next  = tot_wt_reg;
        out_vld_next = out_vld_reg;
        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (load_en)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_entry)
                    begin
                        state_next = S_SCAN;
                        idx_next   = '0;
                        time_next  = '0;
                        fin_next   = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (at_last_idx)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_TICK:
            begin
                time_next = time_inc;
                idx_next  = '0;
                if (done_entry)
                begin
                    fin_next = fin_reg + CNT_W'(1);
                end
                if ((done_entry ? (fin_reg + CNT_W'(1)) : fin_reg) == count_reg)
                begin
                    state_next   = S_OUT;
                    tot_tat_next = '0;
                    tot_wt_next  = '0;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    out_vld_next = 1'b1;
                    tot_tat_next = tat_sum;
                    tot_wt_next  = wt_sum;
                    idx_next     = idx_reg + IDX_W'(1);
                    if (at_last_idx)
                    begin
                        state_next = S_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            fin_reg     <= '0;
            idx_reg     <= '0;
            time_reg    <= '0;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fin_reg     <= fin_next;
            idx_reg     <= idx_next;
            time_reg    <= time_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_tat_reg <= tot_tat_next;
        tot_wt_reg  <= tot_wt_next;
        if (out_fire)
        begin
            out_process_id   <= rd_entry.id;
            completion_time  <= rd_comp;
            turnaround_time  <= tat;
            waiting_time     <= wt;
            last_result      <= at_last_idx;
            total_turnaround <= at_last_idx ? tat_sum : '0;
            total_waiting    <= at_last_idx ? wt_sum : '0;
            entries_dropped  <= ovf_reg;
        end
    end

    assign out_valid = out_vld_reg;

endmodule

FILE: design/psch_regfile.sv
// process entry storage: static fields, remaining and completion times
module psch_regfile
    import psch_pkg::*;
(
    input  logic              clk,
    input  logic              load_en,
    input  logic [IDX_W-1:0]  load_idx,
    input  entry_t            load_entry,
    input  logic              rem_we,
    input  logic              comp_we,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [BUR_W-1:0]  rem_wdata,
    input  logic [TIME_W-1:0] comp_wdata,
    input  logic [IDX_W-1:0]  rd_idx,
    output entry_t            rd_entry,
    output logic [BUR_W-1:0]  rd_rem,
    output logic [TIME_W-1:0] rd_comp
);

    entry_t            ent_reg  [MAX_PROCS];
    logic [BUR_W-1:0]  rem_reg  [MAX_PROCS];
    logic [TIME_W-1:0] comp_reg [MAX_PROCS];

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            ent_reg[load_idx] <= load_entry;
            rem_reg[load_idx] <= load_entry.bur;
        end
        else if (rem_we)
        begin
            rem_reg[wr_idx] <= rem_wdata;
        end
        if (comp_we)
        begin
            comp_reg[wr_idx] <= comp_wdata;
        end
    end

    assign rd_entry = ent_reg[rd_idx];
    assign rd_rem   = rem_reg[rd_idx];
    assign rd_comp  = comp_reg[rd_idx];

endmodule

FILE: design/psch_scan_unit.sv
// shared compare unit: walks the entries one per cycle and keeps the best candidate
module psch_scan_unit
    import psch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              first,
    input  logic [IDX_W-1:0]  idx,
    input  entry_t            rd_entry,
    input  logic [BUR_W-1:0]  rd_rem,
    input  logic [TIME_W-1:0] cur_time,
    output sel_t              sel
);

    logic             found_reg,    found_next;
    logic [IDX_W-1:0] best_reg,     best_next;
    logic [PRI_W-1:0] best_pri_reg, best_pri_next;
    logic [BUR_W-1:0] best_rem_reg, best_rem_next;
    logic             eligible;
    logic             take;

    assign eligible = (TIME_W'(rd_entry.arr) <= cur_time) && (rd_rem != '0);
    // strict less-than keeps the lowest index on equal priority
    assign take = eligible && (first || !found_reg || (rd_entry.pri < best_pri_reg));

    always_comb
    begin
        found_next    = found_reg;
        best_next     = best_reg;
        best_pri_next = best_pri_reg;
        best_rem_next = best_rem_reg;
        if (step)
        begin
            found_next = first ? eligible : (found_reg | eligible);
            if (take)
            begin
                best_next     = idx;
                best_pri_next = rd_entry.pri;
                best_rem_next = rd_rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_pri_reg <= best_pri_next;
        best_rem_reg <= best_rem_next;
    end

    assign sel.found    = found_reg;
    assign sel.best     = best_reg;
    assign sel.best_rem = best_rem_reg;

endmodule

FILE: design/psch_checker.sv
// port-level checks for the preemptive priority scheduler, bound to the top level
module psch_checker
    import psch_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ID_W-1:0]   out_process_id,
    input logic [TIME_W-1:0] completion_time,
    input logic [TIME_W-1:0] turnaround_time,
    input logic [TIME_W-1:0] waiting_time,
    input logic              last_result,
    input logic [TOT_W-1:0]  total_turnaround,
    input logic [TOT_W-1:0]  total_waiting
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_process_id)
            && $stable(completion_time) && $stable(last_result))
        else $error("result changed while stalled");

    // totals only ride on the final result of a run
    a_tot_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> (total_turnaround == '0) && (total_waiting == '0))
        else $error("totals present on a non-final result");

    // an entry always waits less than its turnaround
    a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> waiting_time < turnaround_time)
        else $error("waiting time not below turnaround time");

    // turnaround cannot exceed the completion tick
    a_tat_le_ct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> turnaround_time <= completion_time)
        else $error("turnaround time above completion time");

    // the final total covers at least the final entry
    a_tot_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> total_turnaround >= TOT_W'(turnaround_time))
        else $error("total turnaround below final turnaround");

endmodule

bind preemptive_priority_scheduler psch_checker u_psch_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_process_id   (out_process_id),
    .completion_time  (completion_time),
    .turnaround_time  (turnaround_time),
    .waiting_time     (waiting_time),
    .last_result      (last_result),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting)
);

FILE: verif/tb_preemptive_priority_scheduler.sv
// self-checking testbench for the preemptive priority scheduler
module tb_preemptive_priority_scheduler;
    import psch_pkg::*;

    localparam int HOLD_CYCLES = 12000;
    localparam int RAND_ITEMS  = 300;

    typedef struct packed {
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] ct;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
        logic              last_flag;
        logic [TOT_W-1:0]  tot_tat;
        logic [TOT_W-1:0]  tot_wt;
        logic              dropped;
    } proc_report_t;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [ARR_W-1:0]  arr;
        logic [BUR_W-1:0]  bur;
        logic [PRI_W-1:0]  pri;
        int                reps;
        bit                last_flag;
        bit                typed;
        logic [TIME_W-1:0] ct;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ID_W-1:0]   process_id = '0;
    logic [ARR_W-1:0]  arrival_time = '0;
    logic [BUR_W-1:0]  burst_time = '0;
    logic [PRI_W-1:0]  priority_req = '0;
    logic              last_entry = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ID_W-1:0]   out_process_id;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic              last_result;
    logic [TOT_W-1:0]  total_turnaround;
    logic [TOT_W-1:0]  total_waiting;
    logic              entries_dropped;

    int error_count = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    // predictor state: the batch being loaded
    entry_t            batch_entries [MAX_PROCS];
    logic [BUR_W-1:0]  left_ticks [MAX_PROCS];
    logic [TIME_W-1:0] done_at [MAX_PROCS];
    int                batch_count = 0;
    bit                batch_dropped = 1'b0;
    proc_report_t      sched_reports [$];

    // single-entry rows carry their results typed in
    dir_row_t directed_rows [0:6] = '{
        '{16'h0000, 12'd0,    12'd1,    8'd0,   1,  1'b1, 1'b1, 17'd1,    17'd1,    17'd0},
        '{16'hFFFF, 12'd4095, 12'd4095, 8'd255, 1,  1'b1, 1'b1, 17'd8190, 17'd4095, 17'd0},
        '{16'h1234, 12'd5,    12'd0,    8'd7,   1,  1'b1, 1'b1, 17'd6,    17'd1,    17'd0},
        '{16'h0A00, 12'd0,    12'd4,    8'd3,   1,  1'b0, 1'b0, 17'd0,    17'd0,    17'd0},
        '{16'h0B00, 12'd1,    12'd2,    8'd1,   1,  1'b0, 1'b0, 17'd0,    17'd0,    17'd0},
        '{16'h0C00, 12'd2,    12'd1,    8'd3,   1,  1'b1, 1'b0, 17'd0,    17'd0,    17'd0},
        '{16'h2000, 12'd0,    12'd2,    8'd9,   17, 1'b1, 1'b0, 17'd0,    17'd0,    17'd0}
    };

    preemptive_priority_scheduler DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .process_id       (process_id),
        .arrival_time     (arrival_time),
        .burst_time       (burst_time),
        .priority_req     (priority_req),
        .last_entry       (last_entry),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_process_id   (out_process_id),
        .completion_time  (completion_time),
        .turnaround_time  (turnaround_time),
        .waiting_time     (waiting_time),
        .last_result      (last_result),
        .total_turnaround (total_turnaround),
        .total_waiting    (total_waiting),
        .entries_dropped  (entries_dropped)
    );

    always #5 clk = ~clk;

    task automatic note_error(input string msg);
        $display("%0t ERROR %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // tick-by-tick schedule of the loaded batch, one report per entry in load order
    function automatic void run_priority_schedule();
        logic [TIME_W-1:0] now;
        logic [PRI_W-1:0]  best_pri;
        int                finished;
        int                best;
        bit                found;
        int                sum_tat;
        int                sum_wt;
        proc_report_t      rep;
        now = '0;
        finished = 0;
        while (finished < batch_count)
        begin
            found = 1'b0;
            best = 0;
            best_pri = '0;
            for (int i = 0; i < batch_count; i++)
            begin
                if (TIME_W'(batch_entries[i].arr) <= now && left_ticks[i] != '0)
                begin
                    if (!found || batch_entries[i].pri < best_pri)
                    begin
                        found = 1'b1;
                        best = i;
                        best_pri = batch_entries[i].pri;
                    end
                end
            end
            now = now + TIME_W'(1);
            if (found)
            begin
                left_ticks[best] = left_ticks[best] - BUR_W'(1);
                if (left_ticks[best] == '0)
                begin
                    done_at[best] = now;
                    finished++;
                end
            end
        end
        sum_tat = 0;
        sum_wt = 0;
        for (int i = 0; i < batch_count; i++)
        begin
            rep.pid = batch_entries[i].id;
            rep.ct = done_at[i];
            rep.tat = done_at[i] - TIME_W'(batch_entries[i].arr);
            rep.wt = rep.tat - TIME_W'(batch_entries[i].bur);
            sum_tat += int'(rep.tat);
            sum_wt += int'(rep.wt);
            rep.last_flag = (i == batch_count - 1);
            rep.tot_tat = rep.last_flag ? TOT_W'(sum_tat) : '0;
            rep.tot_wt = rep.last_flag ? TOT_W'(sum_wt) : '0;
            rep.dropped = batch_dropped;
            sched_reports.push_back(rep);
        end
    endfunction

    function automatic void load_process(input entry_t e, input bit last_flag);
        if (e.bur == '0)
            e.bur = BUR_W'(1);
        if (batch_count < MAX_PROCS)
        begin
            batch_entries[batch_count] = e;
            left_ticks[batch_count] = e.bur;
            batch_count++;
        end
        else
            batch_dropped = 1'b1;
        if (last_flag)
        begin
            run_priority_schedule();
            batch_count = 0;
            batch_dropped = 1'b0;
        end
    endfunction

    task automatic offer_request(input entry_t e, input bit last_flag);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        process_id <= e.id;
        arrival_time <= e.arr;
        burst_time <= e.bur;
        priority_req <= e.pri;
        last_entry <= last_flag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        load_process(e, last_flag);
    endtask

    // stop offering until every expected result is out
    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sched_reports.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random back-pressure, plus one long hold on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            out_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_req = 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        proc_report_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (sched_reports.size() == 0)
                note_error("result with none expected");
            else
            begin
                want = sched_reports.pop_front();
                check_field("out_process_id", 32'(out_process_id), 32'(want.pid));
                check_field("completion_time", 32'(completion_time), 32'(want.ct));
                check_field("turnaround_time", 32'(turnaround_time), 32'(want.tat));
                check_field("waiting_time", 32'(waiting_time), 32'(want.wt));
                check_field("last_result", 32'(last_result), 32'(want.last_flag));
                check_field("total_turnaround", 32'(total_turnaround),
                            32'(want.tot_tat));
                check_field("total_waiting", 32'(total_waiting), 32'(want.tot_wt));
                check_field("entries_dropped", 32'(entries_dropped),
                            32'(want.dropped));
            end
        end
    end

    initial
    begin
        entry_t       e;
        proc_report_t typed_rep;
        int           rand_sent;
        int           batch_no;
        int           phase;
        int           n;
        bit           big_batch;
        rand_sent = 0;
        batch_no = 0;
        phase = 0;
        in_idle_pct = 34;
        out_idle_pct = 78;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                e.id = ID_W'(int'(directed_rows[r].id) + k);
                e.arr = directed_rows[r].arr;
                e.bur = directed_rows[r].bur;
                e.pri = directed_rows[r].pri;
                offer_request(e, directed_rows[r].last_flag && k == directed_rows[r].reps - 1);
            end
            if (directed_rows[r].typed)
            begin
                typed_rep.pid = directed_rows[r].id;
                typed_rep.ct = directed_rows[r].ct;
                typed_rep.tat = directed_rows[r].tat;
                typed_rep.wt = directed_rows[r].wt;
                typed_rep.last_flag = 1'b1;
                typed_rep.tot_tat = TOT_W'(directed_rows[r].tat);
                typed_rep.tot_wt = TOT_W'(directed_rows[r].wt);
                typed_rep.dropped = 1'b0;
                void'(sched_reports.pop_back());
                sched_reports.push_back(typed_rep);
            end
        end
        drain_reports();

        while (rand_sent < RAND_ITEMS)
        begin
            if (phase == 0 && rand_sent >= RAND_ITEMS / 3)
            begin
                drain_reports();
                phase = 1;
                in_idle_pct = 78;
                out_idle_pct = 34;
            end
            else if (phase == 1 && rand_sent >= 2 * RAND_ITEMS / 3)
            begin
                drain_reports();
                phase = 2;
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            // long receiver hold while batches keep coming in
            if (batch_no == 2)
                hold_req = 1'b1;
            // few batches with full-range times, and those kept tiny
            big_batch = (batch_no % 8 == 7);
            if (big_batch)
                n = $urandom_range(1, 2);
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3);
            else
                n = $urandom_range(1, MAX_PROCS);
            for (int k = 0; k < n; k++)
            begin
                e.id = ID_W'($urandom_range(0, 65535));
                e.arr = big_batch ? ARR_W'($urandom_range(0, 4095))
                                  : ARR_W'($urandom_range(0, 63));
                e.bur = big_batch ? BUR_W'($urandom_range(1, 4095))
                                  : BUR_W'($urandom_range(1, 15));
                if ($urandom_range(0, 49) == 0)
                    e.bur = '0;
                e.pri = $urandom_range(0, 1) ? PRI_W'($urandom_range(0, 255))
                                             : PRI_W'($urandom_range(0, 3));
                offer_request(e, k == n - 1);
                rand_sent++;
            end
            batch_no++;
        end

        drain_reports();
        repeat (64) @(posedge clk);
        if (error_count == 0)
            $display("tb_preemptive_priority_scheduler: clean");
        else
            $display("tb_preemptive_priority_scheduler: errors");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("tb_preemptive_priority_scheduler: errors");
        $finish;
    end

endmodule
